// File: rtl/lfpd_pkg.sv
// Package for the line follower PD steering unit: widths, reset values, the
// configuration and queue entry types, and the duty saturation function.
// Depends on nothing.
`default_nettype none

package lfpd_pkg;

   localparam int GAIN_FRAC_BITS = 8;

   localparam int SPEED_W    = 8;
   localparam int GAIN_W     = 12;
   localparam int POS_W      = 11;
   localparam int ERR_W      = 12;
   localparam int CSR_DATA_W = 12;
   localparam int CSR_IDX_W  = 2;

   localparam int PROD_W   = GAIN_W + 1 + ERR_W;
   localparam int PD_W     = PROD_W + 1;
   localparam int BASEQ_W  = SPEED_W + GAIN_FRAC_BITS + 1;
   localparam int Q_W      = ((PD_W > BASEQ_W) ? PD_W : BASEQ_W) + 1;
   localparam int WHOLE_W  = Q_W - GAIN_FRAC_BITS;

   localparam logic [POS_W-1:0] POS_LEFT       = POS_W'(2000);
   localparam logic [POS_W-1:0] POS_LEFT_HALF  = POS_W'(1500);
   localparam logic [POS_W-1:0] POS_CENTRE     = POS_W'(1000);
   localparam logic [POS_W-1:0] POS_RIGHT_HALF = POS_W'(500);
   localparam logic [POS_W-1:0] POS_RIGHT      = POS_W'(0);

   localparam logic [SPEED_W-1:0] BASE_DUTY_RESET  = SPEED_W'(200);
   localparam logic [SPEED_W-1:0] DUTY_CAP_RESET   = SPEED_W'(255);
   localparam logic [GAIN_W-1:0]  PROP_GAIN_RESET  = GAIN_W'(97);
   localparam logic [GAIN_W-1:0]  DERIV_GAIN_RESET = GAIN_W'(0);

   localparam int QUEUE_DEPTH = 2;
   localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
   localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_BASE_DUTY  = 2'd0,
      CSR_DUTY_CAP   = 2'd1,
      CSR_PROP_GAIN  = 2'd2,
      CSR_DERIV_GAIN = 2'd3
   } csr_index_type;

   typedef struct packed {
      logic [SPEED_W-1:0] base_duty;
      logic [SPEED_W-1:0] duty_cap;
      logic [GAIN_W-1:0]  prop_gain;
      logic [GAIN_W-1:0]  deriv_gain;
   } cfg_type;

   typedef struct packed {
      logic                    finished;
      logic [POS_W-1:0]        position;
      logic signed [ERR_W-1:0] error;
      logic signed [ERR_W-1:0] delta;
   } entry_type;

   function automatic logic [SPEED_W-1:0] duty_of(input logic signed [Q_W-1:0] q,
                                                  input logic [SPEED_W-1:0] limit);
      logic [WHOLE_W-1:0] whole;
      logic [SPEED_W-1:0] result;
      whole = q[Q_W-1:GAIN_FRAC_BITS];
      if (q <= 0) begin
         result = '0;
      end else if (whole > WHOLE_W'(limit)) begin
         result = limit;
      end else begin
         result = whole[SPEED_W-1:0];
      end
      return result;
   endfunction

endpackage

`default_nettype wire

// File: rtl/line_follow_pd_steering_unit.sv
// Line follower PD steering unit, top level: configuration registers, front end,
// queue and back end. Depends on lfpd_pkg, lfpd_front, lfpd_queue and lfpd_back.
// A result passes from its queue entry through the stage one register to the output register.
// Throughput: one transaction per cycle unless rsp_stall holds, set by the two stage multiply pipeline.
// Reset: gains and speeds return to their defaults, the held position to centre,
// the previous error to zero, and the queue and pipeline empty.
`default_nettype none

module line_follow_pd_steering_unit (
   input  wire logic                              clock,
   input  wire logic                              reset,
   input  wire logic                              req_valid,
   output logic                                   req_stall,
   input  wire logic                              req_sensor_right,
   input  wire logic                              req_sensor_center,
   input  wire logic                              req_sensor_left,
   output logic                                   rsp_valid,
   input  wire logic                              rsp_stall,
   output logic [lfpd_pkg::SPEED_W-1:0]           rsp_left_speed,
   output logic [lfpd_pkg::SPEED_W-1:0]           rsp_right_speed,
   output logic [lfpd_pkg::POS_W-1:0]             rsp_line_position,
   output logic                                   rsp_finished,
   input  wire logic                              csr_write_enable,
   input  wire logic [lfpd_pkg::CSR_IDX_W-1:0]    csr_index,
   input  wire logic [lfpd_pkg::CSR_DATA_W-1:0]   csr_write_data
);
   import lfpd_pkg::*;

   cfg_type       cfg_ff, cfg_in;
   csr_index_type csr_sel;
   logic          queue_full;
   logic          push;
   entry_type     push_entry;
   logic          pop;
   logic          pop_valid;
   entry_type     pop_entry;

   assign csr_sel = csr_index_type'(csr_index);

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_write_enable) begin
         unique case (csr_sel)
            CSR_BASE_DUTY:  cfg_in.base_duty  = csr_write_data[SPEED_W-1:0];
            CSR_DUTY_CAP:   cfg_in.duty_cap   = csr_write_data[SPEED_W-1:0];
            CSR_PROP_GAIN:  cfg_in.prop_gain  = csr_write_data[GAIN_W-1:0];
            CSR_DERIV_GAIN: cfg_in.deriv_gain = csr_write_data[GAIN_W-1:0];
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.base_duty  <= BASE_DUTY_RESET;
         cfg_ff.duty_cap   <= DUTY_CAP_RESET;
         cfg_ff.prop_gain  <= PROP_GAIN_RESET;
         cfg_ff.deriv_gain <= DERIV_GAIN_RESET;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   lfpd_front u_front (
      .clock             (clock),
      .reset             (reset),
      .req_valid         (req_valid),
      .req_stall         (req_stall),
      .req_sensor_right  (req_sensor_right),
      .req_sensor_center (req_sensor_center),
      .req_sensor_left   (req_sensor_left),
      .queue_full        (queue_full),
      .push              (push),
      .push_entry        (push_entry)
   );

   lfpd_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (push),
      .push_entry (push_entry),
      .full       (queue_full),
      .pop        (pop),
      .pop_valid  (pop_valid),
      .pop_entry  (pop_entry)
   );

   lfpd_back u_back (
      .clock             (clock),
      .reset             (reset),
      .cfg               (cfg_ff),
      .pop_valid         (pop_valid),
      .pop_entry         (pop_entry),
      .pop               (pop),
      .rsp_valid         (rsp_valid),
      .rsp_stall         (rsp_stall),
      .rsp_left_speed    (rsp_left_speed),
      .rsp_right_speed   (rsp_right_speed),
      .rsp_line_position (rsp_line_position),
      .rsp_finished      (rsp_finished)
   );

endmodule

`default_nettype wire

// File: rtl/lfpd_front.sv
// Front end: accepts sensor samples, classifies them, keeps the held position
// and previous error, and pushes one entry per transaction into the queue.
// Depends on lfpd_pkg.
`default_nettype none

module lfpd_front (
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic               req_valid,
   output logic                    req_stall,
   input  wire logic               req_sensor_right,
   input  wire logic               req_sensor_center,
   input  wire logic               req_sensor_left,
   input  wire logic               queue_full,
   output logic                    push,
   output lfpd_pkg::entry_type     push_entry
);
   import lfpd_pkg::*;

   logic [POS_W-1:0]        held_position_ff, held_position_in;
   logic signed [ERR_W-1:0] previous_error_ff, previous_error_in;
   logic [POS_W-1:0]        position;
   logic                    finish;
   logic signed [ERR_W:0]   error_wide;
   logic signed [ERR_W:0]   delta_wide;

   assign req_stall = queue_full;
   assign push      = req_valid && !queue_full;

   always_comb begin
      finish   = 1'b0;
      position = held_position_ff;
      unique case ({req_sensor_left, req_sensor_center, req_sensor_right})
         3'b000: begin
            finish   = 1'b1;
            position = POS_RIGHT;
         end
         3'b001: position = POS_RIGHT;
         3'b010: position = POS_CENTRE;
         3'b011: position = POS_RIGHT_HALF;
         3'b100: position = POS_LEFT;
         3'b101: position = POS_CENTRE;
         3'b110: position = POS_LEFT_HALF;
         3'b111: position = held_position_ff;
      endcase
   end

   assign error_wide = signed'((ERR_W+1)'(POS_CENTRE)) - signed'((ERR_W+1)'(position));
   assign delta_wide = (ERR_W+1)'(error_wide[ERR_W-1:0]) - (ERR_W+1)'(previous_error_ff);

   always_comb begin
      push_entry.finished = finish;
      push_entry.position = position;
      push_entry.error    = error_wide[ERR_W-1:0];
      push_entry.delta    = delta_wide[ERR_W-1:0];
   end

   always_comb begin
      held_position_in  = held_position_ff;
      previous_error_in = previous_error_ff;
      if (push && !finish) begin
         held_position_in  = position;
         previous_error_in = error_wide[ERR_W-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         held_position_ff  <= POS_CENTRE;
         previous_error_ff <= '0;
      end else begin
         held_position_ff  <= held_position_in;
         previous_error_ff <= previous_error_in;
      end
   end

endmodule

`default_nettype wire

// File: rtl/lfpd_queue.sv
// Short queue between the front end and the back end, so that each side can
// stall on its own. Depends on lfpd_pkg.
`default_nettype none

module lfpd_queue (
   input  wire logic                clock,
   input  wire logic                reset,
   input  wire logic                push,
   input  wire lfpd_pkg::entry_type push_entry,
   output logic                     full,
   input  wire logic                pop,
   output logic                     pop_valid,
   output lfpd_pkg::entry_type      pop_entry
);
   import lfpd_pkg::*;

   entry_type          entries_ff [QUEUE_DEPTH];
   logic [QPTR_W-1:0]  wr_ptr_ff, wr_ptr_in;
   logic [QPTR_W-1:0]  rd_ptr_ff, rd_ptr_in;
   logic [QCNT_W-1:0]  count_ff, count_in;

   assign full      = (count_ff == QCNT_W'(QUEUE_DEPTH));
   assign pop_valid = (count_ff != '0);
   assign pop_entry = entries_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = push ? QPTR_W'(wr_ptr_ff + 1'b1) : wr_ptr_ff;
      rd_ptr_in = pop  ? QPTR_W'(rd_ptr_ff + 1'b1) : rd_ptr_ff;
      count_in  = count_ff;
      if (push && !pop) begin
         count_in = QCNT_W'(count_ff + 1'b1);
      end else if (pop && !push) begin
         count_in = QCNT_W'(count_ff - 1'b1);
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         entries_ff[wr_ptr_ff] <= push_entry;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   a_no_overflow: assert property (@(posedge clock) disable iff (reset)
      !(push && full && !pop))
      else $error("queue written while full");

   a_no_underflow: assert property (@(posedge clock) disable iff (reset)
      pop |-> pop_valid)
      else $error("queue read while empty");

endmodule

`default_nettype wire

// File: rtl/lfpd_back.sv
// Back end: forms the PD correction from queued entries in a two stage pipeline
// and drives the result channel from an output register. Depends on lfpd_pkg.
`default_nettype none

module lfpd_back (
   input  wire logic                clock,
   input  wire logic                reset,
   input  wire lfpd_pkg::cfg_type   cfg,
   input  wire logic                pop_valid,
   input  wire lfpd_pkg::entry_type pop_entry,
   output logic                     pop,
   output logic                     rsp_valid,
   input  wire logic                rsp_stall,
   output logic [lfpd_pkg::SPEED_W-1:0] rsp_left_speed,
   output logic [lfpd_pkg::SPEED_W-1:0] rsp_right_speed,
   output logic [lfpd_pkg::POS_W-1:0]   rsp_line_position,
   output logic                         rsp_finished
);
   import lfpd_pkg::*;

   logic                     s1_valid_ff;
   logic                     s1_finished_ff;
   logic [POS_W-1:0]         s1_position_ff;
   logic signed [PROD_W-1:0] s1_prop_ff, s1_prop_in;
   logic signed [PROD_W-1:0] s1_deriv_ff, s1_deriv_in;

   logic                     rsp_valid_ff;
   logic [SPEED_W-1:0]       left_speed_ff, left_speed_in;
   logic [SPEED_W-1:0]       right_speed_ff, right_speed_in;
   logic [POS_W-1:0]         line_position_ff;
   logic                     finished_ff;

   logic                     out_ready;
   logic                     s1_ready;
   logic signed [PROD_W-1:0] prop_gain_ext, deriv_gain_ext, error_ext, delta_ext;
   logic signed [Q_W-1:0]    pd_q, base_q;

   assign out_ready = !rsp_valid_ff || !rsp_stall;
   assign s1_ready  = !s1_valid_ff || out_ready;
   assign pop       = pop_valid && s1_ready;

   assign prop_gain_ext  = PROD_W'(signed'({1'b0, cfg.prop_gain}));
   assign deriv_gain_ext = PROD_W'(signed'({1'b0, cfg.deriv_gain}));
   assign error_ext      = PROD_W'(pop_entry.error);
   assign delta_ext      = PROD_W'(pop_entry.delta);
   assign s1_prop_in     = prop_gain_ext * error_ext;
   assign s1_deriv_in    = deriv_gain_ext * delta_ext;

   assign pd_q   = Q_W'(s1_prop_ff) + Q_W'(s1_deriv_ff);
   assign base_q = signed'(Q_W'({cfg.base_duty, {GAIN_FRAC_BITS{1'b0}}}));

   always_comb begin
      left_speed_in  = '0;
      right_speed_in = '0;
      if (!s1_finished_ff) begin
         left_speed_in  = duty_of(Q_W'(base_q - pd_q), cfg.duty_cap);
         right_speed_in = duty_of(Q_W'(base_q + pd_q), cfg.duty_cap);
      end
   end

   always_ff @(posedge clock) begin
      if (pop) begin
         s1_finished_ff <= pop_entry.finished;
         s1_position_ff <= pop_entry.position;
         s1_prop_ff     <= s1_prop_in;
         s1_deriv_ff    <= s1_deriv_in;
      end
      if (s1_valid_ff && out_ready) begin
         left_speed_ff    <= left_speed_in;
         right_speed_ff   <= right_speed_in;
         line_position_ff <= s1_position_ff;
         finished_ff      <= s1_finished_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (s1_ready) begin
            s1_valid_ff <= pop_valid;
         end
         if (out_ready) begin
            rsp_valid_ff <= s1_valid_ff;
         end
      end
   end

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_left_speed    = left_speed_ff;
   assign rsp_right_speed   = right_speed_ff;
   assign rsp_line_position = line_position_ff;
   assign rsp_finished      = finished_ff;

   a_speed_limit: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_left_speed <= cfg.duty_cap && rsp_right_speed <= cfg.duty_cap))
      else $error("duty above the upper limit");

   a_finish_stops: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_finished) |->
      (rsp_left_speed == '0 && rsp_right_speed == '0 && rsp_line_position == '0))
      else $error("finish transaction with non-zero outputs");

endmodule

`default_nettype wire
